// ===== hdl/bsim_pkg.sv =====
// Shared types, codes and constants of the bank switch scanline IRQ mapper.
// Used by bsim_bank_map, bsim_irq_counter and the top level; no dependencies.
package bsim_pkg;

  localparam int PRG_BANK_REGS     = 2;
  localparam int CHR_BANK_REGS     = 6;
  localparam int LAST_VISIBLE_LINE = 239;

  typedef logic [7:0] bank_t;
  typedef logic [PRG_BANK_REGS-1:0][7:0] prg_regs_t;
  typedef logic [CHR_BANK_REGS-1:0][7:0] chr_regs_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_FETCH = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_IRQ_VARIANT     = 2'd0,
    CFG_PRG_BANK_COUNT  = 2'd1,
    CFG_CHR_ROM_PRESENT = 2'd2,
    CFG_FOUR_SCREEN     = 2'd3
  } cfg_index_t;

  // CPU register decode: address & WRITE_DECODE_MASK
  localparam logic [15:0] WRITE_DECODE_MASK = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT   = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA     = 16'h8001;
  localparam logic [15:0] REG_MIRROR        = 16'hA000;
  localparam logic [15:0] REG_RAM_PROTECT   = 16'hA001;
  localparam logic [15:0] REG_IRQ_LATCH     = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD    = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE   = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE    = 16'hE001;

  localparam logic [2:0] COMMAND_MASK   = 3'h7;
  localparam int         PRG_INVERT_BIT = 6;
  localparam int         CHR_INVERT_BIT = 7;
  localparam int         RAM_ENABLE_BIT = 7;
  localparam logic [2:0] FIRST_PRG_CMD  = 3'd6;

  localparam logic [8:0]  PRG_COUNT_RESET = 9'd32;
  localparam chr_regs_t   CHR_RESET = {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
  localparam prg_regs_t   PRG_RESET = {8'd1, 8'd0};

  // Counter control for one item
  typedef struct packed {
    logic       clock_en;
    logic       latch_wr;
    logic       reload_wr;
    logic       disable_wr;
    logic       enable_wr;
    logic       variant;
    logic [7:0] data;
  } irq_ctrl_t;

endpackage

// ===== hdl/bsim_bank_map.sv =====
// Program and pattern bank lookup of the mapper (combinational).
// Depends on bsim_pkg.
module bsim_bank_map (
  input  logic [15:0]        address,
  input  bsim_pkg::prg_regs_t prg_regs,
  input  bsim_pkg::chr_regs_t chr_regs,
  input  logic               prg_invert,
  input  logic               chr_invert,
  input  logic [8:0]         prg_bank_count,
  input  logic               chr_rom_present,
  output bsim_pkg::bank_t    prg_bank,
  output bsim_pkg::bank_t    chr_bank
);

  logic [8:0] count_m1;
  logic [8:0] count_m2;
  logic [7:0] mask;
  logic [7:0] prg_raw;
  logic [1:0] slot;
  logic [2:0] page;
  logic [2:0] page_x;
  logic [2:0] hi_idx;
  logic [7:0] low_reg;

  always_comb begin
    count_m1 = prg_bank_count - 9'd1;
    count_m2 = prg_bank_count - 9'd2;
    mask     = count_m1[7:0];
    slot     = address[14:13];
    if (slot == 2'd1) begin
      prg_raw = prg_regs[1];
    end else if (slot == 2'd3) begin
      prg_raw = count_m1[7:0];
    end else if ((slot == 2'd0) == !prg_invert) begin
      prg_raw = prg_regs[0];
    end else begin
      prg_raw = count_m2[7:0];
    end
    prg_bank = prg_raw & mask;
  end

  always_comb begin
    page    = address[12:10];
    page_x  = page ^ {chr_invert, 2'b00};
    hi_idx  = {1'b0, page_x[1:0]} + 3'd2;
    low_reg = chr_regs[{2'b00, page_x[1]}];
    if (!chr_rom_present) begin
      chr_bank = {5'd0, page};
    end else if (!page_x[2]) begin
      chr_bank = {low_reg[7:1], page_x[0]};
    end else begin
      chr_bank = chr_regs[hi_idx];
    end
  end

endmodule

// ===== hdl/bsim_irq_counter.sv =====
// Scanline interrupt counter: count, reload latch, enable and one-shot flag.
// Depends on bsim_pkg.
module bsim_irq_counter (
  input  logic                clk,
  input  logic                rst,
  input  bsim_pkg::irq_ctrl_t ctrl,
  output logic                fire
);

  logic [7:0] irq_count, irq_count_next;
  logic [7:0] irq_reload, irq_reload_next;
  logic       irq_enabled, irq_enabled_next;
  logic       irq_pending_once, irq_pending_once_next;
  logic [7:0] clocked;
  logic       hit;

  always_comb begin
    irq_count_next        = irq_count;
    irq_reload_next       = irq_reload;
    irq_enabled_next      = irq_enabled;
    irq_pending_once_next = irq_pending_once;
    fire                  = 1'b0;
    clocked = (irq_count == 8'd0) ? irq_reload : irq_count - 8'd1;
    hit     = ctrl.variant ? (irq_count != 8'd0 && clocked == 8'd0) : (clocked == 8'd0);
    if (ctrl.clock_en) begin
      irq_count_next = clocked;
      if (irq_enabled && (hit || irq_pending_once)) begin
        fire                  = 1'b1;
        irq_pending_once_next = 1'b0;
      end
    end
    if (ctrl.latch_wr) begin
      irq_reload_next = ctrl.data;
      if (ctrl.variant && ctrl.data == 8'd0) begin
        irq_pending_once_next = 1'b1;
      end
    end
    if (ctrl.reload_wr) begin
      irq_count_next = 8'd0;
    end
    if (ctrl.disable_wr) begin
      irq_enabled_next = 1'b0;
    end
    if (ctrl.enable_wr) begin
      irq_enabled_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_count        <= 8'd0;
      irq_reload       <= 8'd0;
      irq_enabled      <= 1'b0;
      irq_pending_once <= 1'b0;
    end else begin
      irq_count        <= irq_count_next;
      irq_reload       <= irq_reload_next;
      irq_enabled      <= irq_enabled_next;
      irq_pending_once <= irq_pending_once_next;
    end
  end

endmodule

// ===== hdl/bank_switch_scanline_irq_mapper_top.sv =====
// Top level of the bank switch scanline IRQ mapper: input register, decode,
// mapper state and result register. Depends on bsim_pkg, bsim_bank_map, bsim_irq_counter.
//
// Each transfer on the input channel is one bus event (CPU register write,
// PPU pattern fetch, scanline tick or CPU ROM read) and yields exactly one
// result transfer, in order. An item is held in the input register, then
// decoded and applied to the mapper state as it advances while its result
// is loaded into the output register, so the block takes one item per cycle
// as long as the result register is free or being drained. Input ready
// drops only while the result register holds an untaken result and the input
// register is full. The configuration port is always ready; write it only
// while no item is in flight. mirror_horizontal and sram_enabled report the
// state after the item has been applied.
module bank_switch_scanline_irq_mapper_top (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] address,
  input  logic [7:0]  value,
  input  logic [8:0]  scanline,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        irq_fire,
  output logic        irq_clear,
  output logic [7:0]  bank,
  output logic        mirror_horizontal,
  output logic        sram_enabled,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  // configuration
  logic       irq_variant;
  logic [8:0] prg_bank_count;
  logic       chr_rom_present;
  logic       four_screen;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_mode;
  logic [15:0] s1_address;
  logic [7:0]  s1_value;
  logic [8:0]  s1_scanline;
  logic        advance;

  // mapper state
  logic [2:0]          command_select, command_select_next;
  logic                prg_invert, prg_invert_next;
  logic                chr_invert, chr_invert_next;
  bsim_pkg::prg_regs_t prg_regs, prg_regs_next;
  bsim_pkg::chr_regs_t chr_regs, chr_regs_next;
  logic                last_a12, last_a12_next;
  logic                mirror_bit, mirror_bit_next;
  logic                ram_enable, ram_enable_next;

  bsim_pkg::irq_ctrl_t irq_ctrl;
  logic                fire;
  logic                clear;
  bsim_pkg::bank_t     bank_next;
  bsim_pkg::bank_t     prg_bank;
  bsim_pkg::bank_t     chr_bank;

  assign cfg_ready = 1'b1;

  // Advance the held item when the result register is free or being drained.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_variant     <= 1'b0;
      prg_bank_count  <= bsim_pkg::PRG_COUNT_RESET;
      chr_rom_present <= 1'b1;
      four_screen     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (bsim_pkg::cfg_index_t'(cfg_index))
        bsim_pkg::CFG_IRQ_VARIANT:     irq_variant     <= cfg_data[0];
        bsim_pkg::CFG_PRG_BANK_COUNT:  prg_bank_count  <= cfg_data;
        bsim_pkg::CFG_CHR_ROM_PRESENT: chr_rom_present <= cfg_data[0];
        bsim_pkg::CFG_FOUR_SCREEN:     four_screen     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: load on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode     <= mode;
      s1_address  <= address;
      s1_value    <= value;
      s1_scanline <= scanline;
    end
  end

  bsim_bank_map u_bank_map (
    .address         (s1_address),
    .prg_regs        (prg_regs),
    .chr_regs        (chr_regs),
    .prg_invert      (prg_invert),
    .chr_invert      (chr_invert),
    .prg_bank_count  (prg_bank_count),
    .chr_rom_present (chr_rom_present),
    .prg_bank        (prg_bank),
    .chr_bank        (chr_bank)
  );

  // Decode the held item; state changes only take effect on advance.
  always_comb begin
    command_select_next = command_select;
    prg_invert_next     = prg_invert;
    chr_invert_next     = chr_invert;
    prg_regs_next       = prg_regs;
    chr_regs_next       = chr_regs;
    last_a12_next       = last_a12;
    mirror_bit_next     = mirror_bit;
    ram_enable_next     = ram_enable;
    clear               = 1'b0;
    bank_next           = 8'd0;
    irq_ctrl            = '0;
    irq_ctrl.variant    = irq_variant;
    irq_ctrl.data       = s1_value;
    if (advance) begin
      unique case (bsim_pkg::mode_t'(s1_mode))
        bsim_pkg::MODE_WRITE: begin
          unique case (s1_address & bsim_pkg::WRITE_DECODE_MASK)
            bsim_pkg::REG_BANK_SELECT: begin
              command_select_next = s1_value[2:0] & bsim_pkg::COMMAND_MASK;
              prg_invert_next     = s1_value[bsim_pkg::PRG_INVERT_BIT];
              chr_invert_next     = s1_value[bsim_pkg::CHR_INVERT_BIT];
            end
            bsim_pkg::REG_BANK_DATA: begin
              if (command_select < bsim_pkg::FIRST_PRG_CMD) begin
                chr_regs_next[command_select] = s1_value;
              end else begin
                prg_regs_next[command_select[0]] = s1_value;
              end
            end
            bsim_pkg::REG_MIRROR: begin
              if (!four_screen) begin
                mirror_bit_next = s1_value[0];
              end
            end
            bsim_pkg::REG_RAM_PROTECT: ram_enable_next = s1_value[bsim_pkg::RAM_ENABLE_BIT];
            bsim_pkg::REG_IRQ_LATCH:   irq_ctrl.latch_wr  = 1'b1;
            bsim_pkg::REG_IRQ_RELOAD:  irq_ctrl.reload_wr = 1'b1;
            bsim_pkg::REG_IRQ_DISABLE: begin
              irq_ctrl.disable_wr = 1'b1;
              clear               = 1'b1;
            end
            bsim_pkg::REG_IRQ_ENABLE:  irq_ctrl.enable_wr = 1'b1;
            default: ;
          endcase
        end
        bsim_pkg::MODE_FETCH: begin
          // Drop fetches above pattern space.
          if (s1_address[15:13] == 3'd0) begin
            irq_ctrl.clock_en = s1_address[12] && !last_a12;
            last_a12_next     = s1_address[12];
            bank_next         = chr_bank;
          end
        end
        bsim_pkg::MODE_TICK: begin
          irq_ctrl.clock_en = (s1_scanline <= 9'(bsim_pkg::LAST_VISIBLE_LINE));
        end
        bsim_pkg::MODE_READ: begin
          if (s1_address[15]) begin
            bank_next = prg_bank;
          end
        end
        default: ;
      endcase
    end
  end

  bsim_irq_counter u_irq_counter (
    .clk  (clk),
    .rst  (rst),
    .ctrl (irq_ctrl),
    .fire (fire)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      command_select <= 3'd0;
      prg_invert     <= 1'b0;
      chr_invert     <= 1'b0;
      prg_regs       <= bsim_pkg::PRG_RESET;
      chr_regs       <= bsim_pkg::CHR_RESET;
      last_a12       <= 1'b0;
      mirror_bit     <= 1'b0;
      ram_enable     <= 1'b1;
    end else begin
      command_select <= command_select_next;
      prg_invert     <= prg_invert_next;
      chr_invert     <= chr_invert_next;
      prg_regs       <= prg_regs_next;
      chr_regs       <= chr_regs_next;
      last_a12       <= last_a12_next;
      mirror_bit     <= mirror_bit_next;
      ram_enable     <= ram_enable_next;
    end
  end

  // Result register: hold until the output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irq_fire          <= fire;
      irq_clear         <= clear;
      bank              <= bank_next;
      mirror_horizontal <= mirror_bit_next;
      sram_enabled      <= ram_enable_next;
    end
  end

endmodule

// ===== bench/tb_bank_switch_scanline_irq_mapper_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the bank switch scanline IRQ mapper: directed decode,
// special-case and back-pressure tests, then random bus traffic per configuration.
// Depends on bsim_pkg and bank_switch_scanline_irq_mapper_top.
module tb_bank_switch_scanline_irq_mapper_top;

  // Give up after this many cycles without any transfer on any channel.
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic       irq_fire;
    logic       irq_clear;
    logic [7:0] bank;
    logic       mirror_horizontal;
    logic       sram_enabled;
  } mapper_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = bsim_pkg::MODE_WRITE;
  logic [15:0] address = '0;
  logic [7:0]  value = '0;
  logic [8:0]  scanline = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        irq_fire;
  logic        irq_clear;
  logic [7:0]  bank;
  logic        mirror_horizontal;
  logic        sram_enabled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = bsim_pkg::CFG_IRQ_VARIANT;
  logic [8:0]  cfg_data = '0;

  bank_switch_scanline_irq_mapper_top uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .address           (address),
    .value             (value),
    .scanline          (scanline),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .irq_fire          (irq_fire),
    .irq_clear         (irq_clear),
    .bank              (bank),
    .mirror_horizontal (mirror_horizontal),
    .sram_enabled      (sram_enabled),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 12 ns period.
  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mapper state as the bench sees it: configuration plus cartridge registers.
  // ---------------------------------------------------------------------------
  logic       alt_variant;
  logic [8:0] prg_count;
  logic       chr_rom_cfg;
  logic       four_screen_cfg;

  logic [2:0]          sel_cmd;
  logic                prg_swap;
  logic                chr_swap;
  bsim_pkg::prg_regs_t prg_regs;
  bsim_pkg::chr_regs_t chr_regs;
  logic [7:0]          irq_cnt;
  logic [7:0]          irq_latch;
  logic                irq_on;
  logic                irq_once;
  logic                a12_prev;
  logic                mirror_q;
  logic                ram_on;

  mapper_result_t expected_results[$];
  int mismatch_count = 0;
  int items_sent = 0;

  // Traffic shaping, changed by the tests between phases.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;

  function automatic void reset_mapper_state();
    alt_variant     = 1'b0;
    prg_count       = bsim_pkg::PRG_COUNT_RESET;
    chr_rom_cfg     = 1'b1;
    four_screen_cfg = 1'b0;
    sel_cmd   = '0;
    prg_swap  = 1'b0;
    chr_swap  = 1'b0;
    prg_regs  = bsim_pkg::PRG_RESET;
    chr_regs  = bsim_pkg::CHR_RESET;
    irq_cnt   = '0;
    irq_latch = '0;
    irq_on    = 1'b0;
    irq_once  = 1'b0;
    a12_prev  = 1'b0;
    mirror_q  = 1'b0;
    ram_on    = 1'b1;
  endfunction

  // One counter clock: reload at zero, otherwise count down; report a fire.
  function automatic logic clock_scanline_counter();
    logic [7:0] prior;
    logic       hit;
    prior = irq_cnt;
    if (irq_cnt == 8'd0) irq_cnt = irq_latch;
    else irq_cnt = irq_cnt - 8'd1;
    hit = alt_variant ? (prior != 8'd0 && irq_cnt == 8'd0) : (irq_cnt == 8'd0);
    if (irq_on && (hit || irq_once)) begin
      irq_once = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] prg_bank_at(logic [15:0] a);
    logic [7:0] mask;
    logic [8:0] pick;
    mask = 8'(prg_count - 9'd1);
    case (a[14:13])
      2'd1: pick = {1'b0, prg_regs[1]};
      2'd3: pick = prg_count - 9'd1;
      default: begin
        // Slots 0 and 2 swap between R6 and the second-last bank.
        if ((a[14:13] == 2'd0) == !prg_swap) pick = {1'b0, prg_regs[0]};
        else pick = prg_count - 9'd2;
      end
    endcase
    return pick[7:0] & mask;
  endfunction

  function automatic logic [7:0] chr_bank_at(logic [15:0] a);
    logic [2:0] page;
    logic [7:0] pair;
    page = a[12:10];
    if (!chr_rom_cfg) return {5'd0, page};
    if (chr_swap) page = page ^ 3'd4;
    if (!page[2]) begin
      // 2k pages: R0/R1 with bit 0 taken from the page.
      pair = chr_regs[{2'b00, page[1]}];
      return page[0] ? (pair | 8'h01) : (pair & 8'hFE);
    end
    return chr_regs[page - 3'd2];
  endfunction

  // Apply one bus event to the bench state and return the result it yields.
  function automatic mapper_result_t apply_bus_event(bsim_pkg::mode_t m, logic [15:0] a,
                                                     logic [7:0] v, logic [8:0] line);
    mapper_result_t r;
    r = '0;
    case (m)
      bsim_pkg::MODE_WRITE: begin
        case (a & bsim_pkg::WRITE_DECODE_MASK)
          bsim_pkg::REG_BANK_SELECT: begin
            sel_cmd  = v[2:0] & bsim_pkg::COMMAND_MASK;
            prg_swap = v[bsim_pkg::PRG_INVERT_BIT];
            chr_swap = v[bsim_pkg::CHR_INVERT_BIT];
          end
          bsim_pkg::REG_BANK_DATA: begin
            if (sel_cmd < bsim_pkg::FIRST_PRG_CMD) chr_regs[sel_cmd] = v;
            else prg_regs[1'(sel_cmd - bsim_pkg::FIRST_PRG_CMD)] = v;
          end
          bsim_pkg::REG_MIRROR: if (!four_screen_cfg) mirror_q = v[0];
          bsim_pkg::REG_RAM_PROTECT: ram_on = v[bsim_pkg::RAM_ENABLE_BIT];
          bsim_pkg::REG_IRQ_LATCH: begin
            irq_latch = v;
            if (alt_variant && v == 8'd0) irq_once = 1'b1;
          end
          bsim_pkg::REG_IRQ_RELOAD: irq_cnt = '0;
          bsim_pkg::REG_IRQ_DISABLE: begin
            irq_on = 1'b0;
            r.irq_clear = 1'b1;
          end
          bsim_pkg::REG_IRQ_ENABLE: irq_on = 1'b1;
          default: ;
        endcase
      end
      bsim_pkg::MODE_FETCH: begin
        // Fetches above the pattern tables neither clock nor move A12.
        if (a <= 16'h1FFF) begin
          if (a[12] && !a12_prev) r.irq_fire = clock_scanline_counter();
          a12_prev = a[12];
          r.bank = chr_bank_at(a);
        end
      end
      bsim_pkg::MODE_TICK: begin
        if (line <= bsim_pkg::LAST_VISIBLE_LINE) r.irq_fire = clock_scanline_counter();
      end
      default: begin
        if (a[15]) r.bank = prg_bank_at(a);
      end
    endcase
    r.mirror_horizontal = mirror_q;
    r.sram_enabled = ram_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers.
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then record its expected result.
  task automatic drive_event(bsim_pkg::mode_t m, logic [15:0] a, logic [7:0] v,
                             logic [8:0] line);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    address  <= a;
    value    <= v;
    scanline <= line;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_results.push_back(apply_bus_event(m, a, v, line));
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Write one configuration register with nothing in flight.
  task automatic write_config(bsim_pkg::cfg_index_t idx, logic [8:0] data);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      bsim_pkg::CFG_IRQ_VARIANT:     alt_variant = data[0];
      bsim_pkg::CFG_PRG_BANK_COUNT:  prg_count = data;
      bsim_pkg::CFG_CHR_ROM_PRESENT: chr_rom_cfg = data[0];
      default:                       four_screen_cfg = data[0];
    endcase
  endtask

  task automatic apply_setting(logic variant, logic [8:0] count, logic chr_rom,
                               logic four_scr);
    write_config(bsim_pkg::CFG_IRQ_VARIANT, {8'd0, variant});
    write_config(bsim_pkg::CFG_PRG_BANK_COUNT, count);
    write_config(bsim_pkg::CFG_CHR_ROM_PRESENT, {8'd0, chr_rom});
    write_config(bsim_pkg::CFG_FOUR_SCREEN, {8'd0, four_scr});
  endtask

  // Register address with random don't-care bits, keeping the decode.
  function automatic logic [15:0] reg_addr(logic [15:0] base);
    return base | (16'($urandom) & 16'h1FFE);
  endfunction

  // Random field values at the width of each port.
  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [8:0] any_line();
    return 9'($urandom);
  endfunction

  function automatic logic [15:0] any_addr();
    return 16'($urandom);
  endfunction

  // Mostly visible lines, sometimes lines past the last visible one.
  function automatic logic [8:0] pick_line();
    if ($urandom_range(0, 9) == 0)
      return 9'($urandom_range(bsim_pkg::LAST_VISIBLE_LINE + 1, 511));
    return 9'($urandom_range(0, bsim_pkg::LAST_VISIBLE_LINE));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  task automatic report_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk) begin
    mapper_result_t exp_r;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no expectation, bank %0d", $time, bank);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        report_field("irq_fire", int'(exp_r.irq_fire), int'(irq_fire));
        report_field("irq_clear", int'(exp_r.irq_clear), int'(irq_clear));
        report_field("bank", int'(exp_r.bank), int'(bank));
        report_field("mirror_horizontal", int'(exp_r.mirror_horizontal),
                     int'(mirror_horizontal));
        report_field("sram_enabled", int'(exp_r.sram_enabled), int'(sram_enabled));
      end
    end
  end

  // Watchdog: count cycles in which no channel moves a transfer.
  always @(posedge clk) begin
    int quiet_cycles;
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Default map, bank register writes, inverts, mirroring, RAM enable and a
  // short IRQ countdown under the reset configuration.
  task automatic test_directed_decode();
    drive_event(bsim_pkg::MODE_READ, 16'h7FFF, 8'h00, 9'd0);     // below $8000
    drive_event(bsim_pkg::MODE_READ, 16'h8000, 8'hFF, 9'd511);
    drive_event(bsim_pkg::MODE_READ, 16'hBFFF, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_READ, 16'hC000, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_READ, 16'hFFFF, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_FETCH, 16'h0000, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_FETCH, 16'h1FFF, 8'h00, 9'd0);    // A12 rises, IRQ off
    drive_event(bsim_pkg::MODE_FETCH, 16'h2000, 8'h00, 9'd0);    // above pattern space
    drive_event(bsim_pkg::MODE_FETCH, 16'hFFFF, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_BANK_SELECT, 8'hC7, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_BANK_DATA, 8'hFF, 9'd0);
    drive_event(bsim_pkg::MODE_READ, 16'h8000, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_READ, 16'hC000, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_FETCH, 16'h0400, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, 16'h6000, 8'hFF, 9'd0);    // no effect below $8000
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_MIRROR, 8'h01, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_RAM_PROTECT, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_IRQ_LATCH, 8'h02, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_IRQ_RELOAD, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_IRQ_ENABLE, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_TICK, 16'hFFFF, 8'hFF, 9'(bsim_pkg::LAST_VISIBLE_LINE));
    drive_event(bsim_pkg::MODE_TICK, 16'h0000, 8'h00, 9'(bsim_pkg::LAST_VISIBLE_LINE + 1));
    drive_event(bsim_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd511);
    drive_event(bsim_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd100);   // counter reaches zero
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_IRQ_DISABLE, 8'h00, 9'd0);
  endtask

  // Alternate counter with a zero latch, no pattern ROM, four-screen and an
  // odd bank count.
  task automatic test_special_cases();
    apply_setting(1'b1, 9'd3, 1'b0, 1'b1);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_IRQ_LATCH, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_IRQ_ENABLE, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd10);    // queued interrupt fires
    drive_event(bsim_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd11);    // and only once
    drive_event(bsim_pkg::MODE_FETCH, 16'h0C00, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_WRITE, bsim_pkg::REG_MIRROR, 8'h00, 9'd0);  // four-screen
    drive_event(bsim_pkg::MODE_READ, 16'hE000, 8'h00, 9'd0);
    drive_event(bsim_pkg::MODE_READ, 16'hC000, 8'h00, 9'd0);
  endtask

  // Random traffic: mostly bank setup and IRQ countdown sequences with random
  // content, the rest mirroring/RAM writes and unconstrained noise.
  task automatic run_traffic(int count);
    int target;
    int pick;
    int steps;
    logic [7:0] latch_val;
    logic [11:0] offset;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // Select a register, load it, then look banks up.
        drive_event(bsim_pkg::MODE_WRITE, reg_addr(bsim_pkg::REG_BANK_SELECT), any_byte(),
                    any_line());
        drive_event(bsim_pkg::MODE_WRITE, reg_addr(bsim_pkg::REG_BANK_DATA), any_byte(),
                    any_line());
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0)
            drive_event(bsim_pkg::MODE_READ, any_addr(), any_byte(), any_line());
          else
            drive_event(bsim_pkg::MODE_FETCH, {3'd0, 13'($urandom)}, any_byte(),
                        any_line());
        end
      end else if (pick < 65) begin
        // Arm the counter and clock it with ticks and with fetches that raise A12.
        steps = $urandom_range(0, 9);
        latch_val = (steps == 0) ? 8'h00 : (steps == 1) ? 8'hFF : 8'($urandom_range(1, 8));
        drive_event(bsim_pkg::MODE_WRITE, reg_addr(bsim_pkg::REG_IRQ_LATCH), latch_val,
                    any_line());
        if ($urandom_range(0, 1) == 0)
          drive_event(bsim_pkg::MODE_WRITE, reg_addr(bsim_pkg::REG_IRQ_RELOAD), any_byte(),
                      any_line());
        drive_event(bsim_pkg::MODE_WRITE, reg_addr(bsim_pkg::REG_IRQ_ENABLE), any_byte(),
                    any_line());
        steps = $urandom_range(2, 16);
        repeat (steps) begin
          pick = $urandom_range(0, 99);
          offset = 12'($urandom);
          if (pick < 45) begin
            drive_event(bsim_pkg::MODE_TICK, any_addr(), any_byte(), pick_line());
          end else if (pick < 85) begin
            drive_event(bsim_pkg::MODE_FETCH, {4'h0, offset}, any_byte(), any_line());
            drive_event(bsim_pkg::MODE_FETCH, {4'h1, 12'($urandom)}, any_byte(),
                        any_line());
          end else if (pick < 92) begin
            drive_event(bsim_pkg::MODE_WRITE, reg_addr(bsim_pkg::REG_IRQ_DISABLE),
                        any_byte(), any_line());
            if ($urandom_range(0, 1) == 0)
              drive_event(bsim_pkg::MODE_WRITE, reg_addr(bsim_pkg::REG_IRQ_ENABLE),
                          any_byte(), any_line());
          end else begin
            drive_event(bsim_pkg::MODE_FETCH, {2'd0, 14'($urandom)}, any_byte(),
                        any_line());
          end
        end
      end else if (pick < 75) begin
        drive_event(bsim_pkg::MODE_WRITE,
                    reg_addr(($urandom_range(0, 1) == 0) ? bsim_pkg::REG_MIRROR
                                                         : bsim_pkg::REG_RAM_PROTECT),
                    any_byte(), any_line());
      end else begin
        drive_event(bsim_pkg::mode_t'($urandom_range(0, 3)), any_addr(), any_byte(),
                    any_line());
      end
    end
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // block fills and stalls its input; then pause the sender until all is back.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 300;
    run_traffic(40);
    drain_results();
  endtask

  // Walk several configurations, extremes included, and run each under two
  // of the idle phases.
  task automatic test_config_sweep();
    int phase;
    int idle_table[4][2];
    idle_table = '{'{0, 0}, '{87, 0}, '{0, 87}, '{23, 23}};
    phase = 0;
    for (int s = 0; s < 7; s++) begin
      case (s)
        0: apply_setting(1'b1, 9'd2, 1'b1, 1'b0);
        1: apply_setting(1'b0, 9'd256, 1'b1, 1'b1);
        2: apply_setting(1'b1, 9'd256, 1'b0, 1'b0);
        3: apply_setting(1'b0, 9'd8, 1'b1, 1'b0);
        4: apply_setting(1'b1, 9'd24, 1'b1, 1'b1);
        5: apply_setting(1'b0, 9'd32, 1'b1, 1'b0);
        default: apply_setting(1'($urandom_range(0, 1)), 9'(1 << $urandom_range(1, 8)),
                               $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
      endcase
      repeat (2) begin
        sender_idle_pct = idle_table[phase % 4][0];
        receiver_stall_pct = idle_table[phase % 4][1];
        phase++;
        run_traffic(100);
      end
    end
  endtask

  // Main sequence: reset once, run the tests, settle and report.
  initial begin
    reset_mapper_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_decode();
    test_special_cases();
    test_backpressure();
    test_config_sweep();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bsim_pkg.sv
hdl/bsim_bank_map.sv
hdl/bsim_irq_counter.sv
hdl/bank_switch_scanline_irq_mapper_top.sv
bench/tb_bank_switch_scanline_irq_mapper_top.sv
